@@ sv/prechg_pkg.sv @@
package prechg_pkg;

    // Field and register widths.
    localparam int KIND_W      = 2;
    localparam int MV_W        = 16;
    localparam int TICKS_W     = 10;
    localparam int ATTEMPT_W   = 4;
    localparam int PERMILLE_W  = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Default width of the voltage samples that the ratio test uses.
    localparam int SAMPLE_BITS_DEF = 16;

    // Full scale of the permille ratio.
    localparam int PERMILLE_SCALE = 1000;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RETRY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TRIES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PACK  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd4;

    // Configuration reset values.
    localparam logic [TICKS_W-1:0]    TIMEOUT_RST   = 10'd100;
    localparam logic [TICKS_W-1:0]    COOLDOWN_RST  = 10'd500;
    localparam logic [ATTEMPT_W-1:0]  MAX_TRIES_RST = 4'd3;
    localparam logic [MV_W-1:0]       MIN_PACK_RST  = 16'd100;
    localparam logic [PERMILLE_W-1:0] THRESHOLD_RST = 10'd900;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MV_W-1:0]   pack_mv;
        logic [MV_W-1:0]   load_mv;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                start_accepted;
        logic                precharge_fet_on;
        logic                discharge_fet_on;
        logic                is_complete;
        logic                is_faulted;
    } t_out_item;

endpackage

@@ sv/precharge_sequencer.sv @@
// Channel  | Direction | Handshake                   | Payload
// in       | input     | i_in_valid / o_in_ready     | i_in_item  (prechg_pkg::t_in_item)
// out      | output    | o_out_valid / i_out_ready   | o_out_item (prechg_pkg::t_out_item)
// cfg      | input     | i_cfg_wr_en, no wait        | i_cfg_index, i_cfg_data
//
// Every item gives exactly one result, via the input and result registers.
// One item is accepted per cycle while o_in_ready is high; the sequencer
// state updates as an item moves from the input register into the result
// register. Reset (synchronous, active low) empties both registers, opens
// both FETs and loads the default configuration.
// A stalled result holds the result register; the input register still takes
// one more item, after which o_in_ready drops until the result is taken.
module precharge_sequencer #(
    parameter int SAMPLE_BITS = prechg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  prechg_pkg::t_in_item                i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output prechg_pkg::t_out_item               o_out_item,
    input  logic                                i_cfg_wr_en,
    input  logic [prechg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [prechg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TW = prechg_pkg::TICKS_W;
    localparam int AW = prechg_pkg::ATTEMPT_W;
    // Width of the cross products in the ratio test.
    localparam int PW = SAMPLE_BITS + prechg_pkg::PERMILLE_W;
    // Width for the pack against minimum compare.
    localparam int MW = (SAMPLE_BITS > prechg_pkg::MV_W) ? SAMPLE_BITS : prechg_pkg::MV_W;

    // Phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACTIVE = 3'd1;
    localparam logic [2:0] PH_COOL   = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_FAULT  = 3'd4;

    // Configuration registers.
    logic [TW-1:0]                      r_timeout;
    logic [TW-1:0]                      r_cooldown;
    logic [AW-1:0]                      r_max_tries;
    logic [prechg_pkg::MV_W-1:0]        r_min_pack;
    logic [prechg_pkg::PERMILLE_W-1:0]  r_threshold;

    // Sequencer state.
    logic [2:0]     r_phase;
    logic [AW-1:0]  r_failed;
    logic [TW-1:0]  r_elapsed;
    logic           r_pch;
    logic           r_dch;

    logic [2:0]     n_phase;
    logic [AW-1:0]  n_failed;
    logic [TW-1:0]  n_elapsed;
    logic           n_pch;
    logic           n_dch;

    // Pipeline registers.
    logic                   r_in_valid;
    prechg_pkg::t_in_item   r_in_item;
    logic                   r_out_valid;
    prechg_pkg::t_out_item  r_out_item;
    prechg_pkg::t_out_item  n_out_item;

    logic                   adv;
    logic                   move;

    // Ratio test terms.
    logic [SAMPLE_BITS-1:0] pack_s;
    logic [SAMPLE_BITS-1:0] load_s;
    logic [PW-1:0]          load_prod;
    logic [PW-1:0]          pack_prod;
    logic                   ratio_ok;
    logic [TW-1:0]          elapsed_inc;
    logic [AW-1:0]          failed_inc;

    // Handshake: the result register frees when empty or taken.
    assign adv         = !r_out_valid || i_out_ready;
    assign move        = r_in_valid && adv;
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= prechg_pkg::TIMEOUT_RST;
            r_cooldown  <= prechg_pkg::COOLDOWN_RST;
            r_max_tries <= prechg_pkg::MAX_TRIES_RST;
            r_min_pack  <= prechg_pkg::MIN_PACK_RST;
            r_threshold <= prechg_pkg::THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                prechg_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TW-1:0];
                prechg_pkg::CFG_COOLDOWN:  r_cooldown  <= i_cfg_data[TW-1:0];
                prechg_pkg::CFG_MAX_TRIES: r_max_tries <= i_cfg_data[AW-1:0];
                prechg_pkg::CFG_MIN_PACK:  r_min_pack  <= i_cfg_data[prechg_pkg::MV_W-1:0];
                prechg_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[prechg_pkg::PERMILLE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Samples cut or widened to the sample width, then the cross products.
    assign pack_s    = SAMPLE_BITS'(r_in_item.pack_mv);
    assign load_s    = SAMPLE_BITS'(r_in_item.load_mv);
    assign load_prod = PW'(load_s) * PW'(prechg_pkg::PERMILLE_SCALE);
    assign pack_prod = PW'(pack_s) * PW'(r_threshold);
    assign ratio_ok  = (MW'(pack_s) > MW'(r_min_pack)) && (load_prod >= pack_prod);

    // Saturating counter increments.
    assign elapsed_inc = (r_elapsed == {TW{1'b1}}) ? r_elapsed : r_elapsed + TW'(1);
    assign failed_inc  = (r_failed == {AW{1'b1}}) ? r_failed : r_failed + AW'(1);

    // Next state and result for the item in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_failed   = r_failed;
        n_elapsed  = r_elapsed;
        n_pch      = r_pch;
        n_dch      = r_dch;
        n_out_item = '0;
        n_out_item.status = prechg_pkg::ST_BUSY;

        case (r_in_item.kind)
            prechg_pkg::KIND_TICK: begin
                case (r_phase)
                    PH_ACTIVE: begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_timeout) begin
                            // The attempt timed out.
                            n_pch    = 1'b0;
                            n_failed = failed_inc;
                            if (failed_inc >= r_max_tries) begin
                                n_phase = PH_FAULT;
                                n_out_item.status = prechg_pkg::ST_FAIL;
                            end else begin
                                n_phase   = PH_COOL;
                                n_elapsed = '0;
                                n_out_item.status = prechg_pkg::ST_RETRY;
                            end
                        end else if (ratio_ok) begin
                            n_dch   = 1'b1;
                            n_pch   = 1'b0;
                            n_phase = PH_DONE;
                            n_out_item.status = prechg_pkg::ST_OK;
                        end
                    end
                    PH_COOL: begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_cooldown) begin
                            // Cooldown over: retry and test the same samples.
                            n_pch     = 1'b1;
                            n_elapsed = '0;
                            n_phase   = PH_ACTIVE;
                            if (ratio_ok) begin
                                n_dch   = 1'b1;
                                n_pch   = 1'b0;
                                n_phase = PH_DONE;
                                n_out_item.status = prechg_pkg::ST_OK;
                            end
                        end else begin
                            n_out_item.status = prechg_pkg::ST_RETRY;
                        end
                    end
                    PH_DONE: n_out_item.status = prechg_pkg::ST_OK;
                    default: ;
                endcase
            end
            prechg_pkg::KIND_START: begin
                if (r_phase != PH_ACTIVE && r_phase != PH_COOL) begin
                    n_phase   = PH_ACTIVE;
                    n_failed  = '0;
                    n_elapsed = '0;
                    n_pch     = 1'b1;
                    n_dch     = 1'b0;
                    n_out_item.start_accepted = 1'b1;
                end
            end
            prechg_pkg::KIND_RESET: begin
                n_pch     = 1'b0;
                n_dch     = 1'b0;
                n_phase   = PH_IDLE;
                n_failed  = '0;
                n_elapsed = '0;
            end
            default: ;
        endcase

        n_out_item.precharge_fet_on = n_pch;
        n_out_item.discharge_fet_on = n_dch;
        n_out_item.is_complete      = (n_phase == PH_DONE);
        n_out_item.is_faulted       = (n_phase == PH_FAULT);
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_failed    <= '0;
            r_elapsed   <= '0;
            r_pch       <= 1'b0;
            r_dch       <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (move) begin
                r_phase   <= n_phase;
                r_failed  <= n_failed;
                r_elapsed <= n_elapsed;
                r_pch     <= n_pch;
                r_dch     <= n_dch;
            end
        end
        if (move) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

@@ sv/prechg_checker.sv @@
module prechg_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input prechg_pkg::t_out_item  i_out_item
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // No result is shown in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A complete sequence has the main FET closed and the precharge FET open.
    a_complete_fets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.is_complete |->
            i_out_item.discharge_fet_on && !i_out_item.precharge_fet_on)
        else $error("complete with wrong FET drive");

    // An accepted start begins a fresh attempt.
    a_start_fets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.start_accepted |->
            i_out_item.precharge_fet_on && !i_out_item.discharge_fet_on &&
            i_out_item.status == prechg_pkg::ST_BUSY)
        else $error("accepted start with wrong outputs");

    // A failed status leaves the block in fault with precharge open.
    a_fail_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.status == prechg_pkg::ST_FAIL |->
            i_out_item.is_faulted && !i_out_item.precharge_fet_on)
        else $error("failed status without fault");

endmodule

bind precharge_sequencer prechg_checker u_prechg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

@@ sim/precharge_sequencer_test.sv @@
`timescale 1ns / 100ps

module precharge_sequencer_test;

    // The block ignores the fourth item kind; it has no name in the package.
    localparam logic [prechg_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int MAX_IDLE        = 18;
    localparam int QUIET_EVERY     = 40;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 125;

    typedef enum logic [2:0] {PH_IDLE, PH_ACTIVE, PH_COOL, PH_DONE, PH_FAULT} t_phase;
    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind                            act;
        prechg_pkg::t_in_item                item;
        int                                  gap;
        logic [prechg_pkg::CFG_INDEX_W-1:0]  idx;
        logic [prechg_pkg::CFG_DATA_W-1:0]   data;
    } t_feed_op;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    prechg_pkg::t_in_item               in_item   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    prechg_pkg::t_out_item              out_item;
    logic                               cfg_wr_en = 1'b0;
    logic [prechg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [prechg_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Sequencer state and register copies kept by the predictor.
    t_phase                            seq_phase    = PH_IDLE;
    logic [prechg_pkg::ATTEMPT_W-1:0]  fail_cnt     = '0;
    logic [prechg_pkg::TICKS_W-1:0]    elapsed      = '0;
    logic                              pre_fet      = 1'b0;
    logic                              main_fet     = 1'b0;
    logic [prechg_pkg::TICKS_W-1:0]    reg_timeout  = prechg_pkg::TIMEOUT_RST;
    logic [prechg_pkg::TICKS_W-1:0]    reg_cooldown = prechg_pkg::COOLDOWN_RST;
    logic [prechg_pkg::ATTEMPT_W-1:0]  reg_tries    = prechg_pkg::MAX_TRIES_RST;
    logic [prechg_pkg::MV_W-1:0]       reg_min_pack = prechg_pkg::MIN_PACK_RST;
    logic [prechg_pkg::PERMILLE_W-1:0] reg_thresh   = prechg_pkg::THRESHOLD_RST;

    t_feed_op              feed_q[$];
    prechg_pkg::t_out_item charge_results[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  item_total     = 0;
    int  taken_count    = 0;
    int  hold_left      = 0;
    int  cur_gap        = 0;
    int  stall_left     = 0;
    bit  sender_quiet   = 1'b0;
    bit  sink_quiet     = 1'b0;

    precharge_sequencer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Success test: the pack must be above the minimum and the load ratio at or above threshold.
    function automatic logic [prechg_pkg::STATUS_W-1:0] try_close(
            logic [prechg_pkg::MV_W-1:0] pack, logic [prechg_pkg::MV_W-1:0] load);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = load;
        lhs = lhs * prechg_pkg::PERMILLE_SCALE;
        rhs = reg_thresh;
        rhs = rhs * pack;
        if (pack > reg_min_pack && lhs >= rhs) begin
            main_fet = 1'b1;
            pre_fet = 1'b0;
            seq_phase = PH_DONE;
            return prechg_pkg::ST_OK;
        end
        return prechg_pkg::ST_BUSY;
    endfunction

    // Advances the sequencer by one item and returns the result it should report.
    function automatic prechg_pkg::t_out_item step_sequencer(prechg_pkg::t_in_item it);
        prechg_pkg::t_out_item res;
        res = '0;
        case (it.kind)
            prechg_pkg::KIND_TICK: begin
                if (seq_phase == PH_ACTIVE) begin
                    if (elapsed != '1) elapsed++;
                    if (elapsed >= reg_timeout) begin
                        pre_fet = 1'b0;
                        if (fail_cnt != '1) fail_cnt++;
                        if (fail_cnt >= reg_tries) begin
                            seq_phase = PH_FAULT;
                            res.status = prechg_pkg::ST_FAIL;
                        end else begin
                            seq_phase = PH_COOL;
                            elapsed = '0;
                            res.status = prechg_pkg::ST_RETRY;
                        end
                    end else begin
                        res.status = try_close(it.pack_mv, it.load_mv);
                    end
                end else if (seq_phase == PH_COOL) begin
                    if (elapsed != '1) elapsed++;
                    if (elapsed >= reg_cooldown) begin
                        pre_fet = 1'b1;
                        elapsed = '0;
                        seq_phase = PH_ACTIVE;
                        res.status = try_close(it.pack_mv, it.load_mv);
                    end else begin
                        res.status = prechg_pkg::ST_RETRY;
                    end
                end else if (seq_phase == PH_DONE) begin
                    res.status = prechg_pkg::ST_OK;
                end
            end
            prechg_pkg::KIND_START: begin
                if (seq_phase != PH_ACTIVE && seq_phase != PH_COOL) begin
                    seq_phase = PH_ACTIVE;
                    fail_cnt = '0;
                    elapsed = '0;
                    pre_fet = 1'b1;
                    main_fet = 1'b0;
                    res.start_accepted = 1'b1;
                end
            end
            prechg_pkg::KIND_RESET: begin
                pre_fet = 1'b0;
                main_fet = 1'b0;
                seq_phase = PH_IDLE;
                fail_cnt = '0;
                elapsed = '0;
            end
            default: begin
            end
        endcase
        res.precharge_fet_on = pre_fet;
        res.discharge_fet_on = main_fet;
        res.is_complete = (seq_phase == PH_DONE);
        res.is_faulted = (seq_phase == PH_FAULT);
        return res;
    endfunction

    // Registers keep only their own width of the write data.
    function automatic void load_register(logic [prechg_pkg::CFG_INDEX_W-1:0] idx,
                                          logic [prechg_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            prechg_pkg::CFG_TIMEOUT:   reg_timeout = data[prechg_pkg::TICKS_W-1:0];
            prechg_pkg::CFG_COOLDOWN:  reg_cooldown = data[prechg_pkg::TICKS_W-1:0];
            prechg_pkg::CFG_MAX_TRIES: reg_tries = data[prechg_pkg::ATTEMPT_W-1:0];
            prechg_pkg::CFG_MIN_PACK:  reg_min_pack = data[prechg_pkg::MV_W-1:0];
            prechg_pkg::CFG_THRESHOLD: reg_thresh = data[prechg_pkg::PERMILLE_W-1:0];
            default: begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("mismatch on %s: got %0h, want %0h (result %0d, cycle %0d)",
                 what, got, want, taken_count, cycle_count);
        mismatch_count++;
    endtask

    // Each item carries the idle gap the sender leaves after it is accepted.
    task automatic push_item(input logic [prechg_pkg::KIND_W-1:0] kind,
                             input logic [prechg_pkg::MV_W-1:0] pack,
                             input logic [prechg_pkg::MV_W-1:0] load);
        t_feed_op op;
        if (item_total % QUIET_EVERY == 0) sender_quiet = ($urandom_range(0, 2) == 0);
        item_total++;
        op.act = OP_ITEM;
        op.item.kind = kind;
        op.item.pack_mv = pack;
        op.item.load_mv = load;
        op.gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        op.idx = '0;
        op.data = '0;
        feed_q.push_back(op);
    endtask

    // Upper bits above the register width are filled with noise.
    task automatic push_cfg(input logic [prechg_pkg::CFG_INDEX_W-1:0] idx, input int value,
                            input int width);
        t_feed_op op;
        op.act = OP_CFG;
        op.item = '0;
        op.gap = 0;
        op.idx = idx;
        op.data = prechg_pkg::CFG_DATA_W'(($urandom << width) | value);
        feed_q.push_back(op);
    endtask

    task automatic push_drain();
        t_feed_op op;
        op.act = OP_DRAIN;
        op.item = '0;
        op.gap = 0;
        op.idx = '0;
        op.data = '0;
        feed_q.push_back(op);
    endtask

    task automatic push_settings(input int tmo, input int cool, input int tries,
                                 input int minp, input int thr);
        push_cfg(prechg_pkg::CFG_TIMEOUT, tmo, prechg_pkg::TICKS_W);
        push_cfg(prechg_pkg::CFG_COOLDOWN, cool, prechg_pkg::TICKS_W);
        push_cfg(prechg_pkg::CFG_MAX_TRIES, tries, prechg_pkg::ATTEMPT_W);
        push_cfg(prechg_pkg::CFG_MIN_PACK, minp, prechg_pkg::MV_W);
        push_cfg(prechg_pkg::CFG_THRESHOLD, thr, prechg_pkg::PERMILLE_W);
    endtask

    // Sender: presents queued items, writes registers only once every result is back.
    always @(posedge clk) begin : feed_proc
        t_feed_op op;
        logic     vld_nxt;
        logic     wr_nxt;
        vld_nxt = in_valid;
        wr_nxt = 1'b0;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                charge_results.push_back(step_sequencer(in_item));
                vld_nxt = 1'b0;
                hold_left = cur_gap;
            end
            if (!vld_nxt && feed_q.size() > 0) begin
                if (hold_left > 0) begin
                    hold_left--;
                end else begin
                    op = feed_q[0];
                    case (op.act)
                        OP_ITEM: begin
                            in_item <= op.item;
                            cur_gap = op.gap;
                            vld_nxt = 1'b1;
                            void'(feed_q.pop_front());
                        end
                        OP_CFG: begin
                            if (charge_results.size() == 0) begin
                                cfg_index <= op.idx;
                                cfg_data <= op.data;
                                wr_nxt = 1'b1;
                                load_register(op.idx, op.data);
                                void'(feed_q.pop_front());
                            end
                        end
                        default: begin
                            if (charge_results.size() == 0) void'(feed_q.pop_front());
                        end
                    endcase
                end
            end
        end
        in_valid <= vld_nxt;
        cfg_wr_en <= wr_nxt;
    end

    // Receiver: stalls at random and checks each result against the oldest prediction.
    always @(posedge clk) begin : check_proc
        prechg_pkg::t_out_item want;
        logic                  rdy_nxt;
        rdy_nxt = out_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (charge_results.size() == 0) begin
                    flag_mismatch("result with nothing awaited", 8'(out_item), 8'd0);
                end else begin
                    want = charge_results.pop_front();
                    if (out_item.status !== want.status)
                        flag_mismatch("status", 8'(out_item.status), 8'(want.status));
                    if (out_item.start_accepted !== want.start_accepted)
                        flag_mismatch("start_accepted", 8'(out_item.start_accepted),
                                      8'(want.start_accepted));
                    if (out_item.precharge_fet_on !== want.precharge_fet_on)
                        flag_mismatch("precharge_fet_on", 8'(out_item.precharge_fet_on),
                                      8'(want.precharge_fet_on));
                    if (out_item.discharge_fet_on !== want.discharge_fet_on)
                        flag_mismatch("discharge_fet_on", 8'(out_item.discharge_fet_on),
                                      8'(want.discharge_fet_on));
                    if (out_item.is_complete !== want.is_complete)
                        flag_mismatch("is_complete", 8'(out_item.is_complete),
                                      8'(want.is_complete));
                    if (out_item.is_faulted !== want.is_faulted)
                        flag_mismatch("is_faulted", 8'(out_item.is_faulted),
                                      8'(want.is_faulted));
                end
                taken_count++;
                if (taken_count % QUIET_EVERY == 0) sink_quiet = ($urandom_range(0, 2) == 0);
                stall_left = sink_quiet ? 0 : $urandom_range(0, MAX_IDLE);
                rdy_nxt = 1'b0;
            end
            if (!rdy_nxt) begin
                if (stall_left > 0) stall_left--;
                else rdy_nxt = 1'b1;
            end
        end
        out_ready <= rdy_nxt;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int tmo;
        int cool;
        int tries;
        int minp;
        int thr;
        int roll;
        int pack_v;
        int load_v;
        int tmp;

        // Short attempts so that timeout, cooldown and fault show up quickly.
        push_settings(3, 2, 2, 100, 900);
        push_item(prechg_pkg::KIND_TICK, 16'd5000, 16'd5000);
        push_item(KIND_SPARE, 16'hFFFF, 16'hFFFF);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd899);
        // Pack equal to the minimum never succeeds, whatever the load.
        push_item(prechg_pkg::KIND_TICK, 16'd100, 16'hFFFF);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd0);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd0);
        // Cooldown ends and the success test runs on this tick, at exact threshold.
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd900);
        push_item(prechg_pkg::KIND_TICK, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'hFFFF, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'd0, 16'd0);
        // Timeout is tested before success.
        push_item(prechg_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd100);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd100);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd100);
        push_item(prechg_pkg::KIND_TICK, 16'd2000, 16'd100);
        push_item(prechg_pkg::KIND_TICK, 16'd2000, 16'd100);
        push_item(prechg_pkg::KIND_TICK, 16'd2000, 16'd2000);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_RESET, 16'hFFFF, 16'hFFFF);

        // Zero limits: the first tick times out and faults at once.
        push_drain();
        push_settings(0, 0, 0, 0, 1023);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd1023);

        // A threshold above full scale needs the load above the pack.
        push_drain();
        push_cfg(prechg_pkg::CFG_TIMEOUT, 1023, prechg_pkg::TICKS_W);
        push_cfg(prechg_pkg::CFG_MAX_TRIES, 15, prechg_pkg::ATTEMPT_W);
        push_item(prechg_pkg::KIND_START, 16'd0, 16'd0);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd1022);
        push_item(prechg_pkg::KIND_TICK, 16'd1000, 16'd1023);

        // Random phases: mostly start-then-ticks with occasional commands and noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            push_drain();
            case (ph)
                0: begin
                    tmo = 1; cool = 0; tries = 1; minp = 0; thr = 0;
                end
                1: begin
                    tmo = 1023; cool = 1023; tries = 15; minp = 65535; thr = 1000;
                end
                default: begin
                    tmo = $urandom_range(1, 12);
                    cool = $urandom_range(0, 8);
                    tries = $urandom_range(1, 5);
                    minp = $urandom_range(0, 3000);
                    thr = $urandom_range(0, 1023);
                end
            endcase
            push_settings(tmo, cool, tries, minp, thr);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) push_drain();
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    push_item(prechg_pkg::KIND_START, prechg_pkg::MV_W'($urandom),
                              prechg_pkg::MV_W'($urandom));
                end else if (roll < 7) begin
                    push_item(prechg_pkg::KIND_RESET, prechg_pkg::MV_W'($urandom),
                              prechg_pkg::MV_W'($urandom));
                end else if (roll < 9) begin
                    push_item(KIND_SPARE, prechg_pkg::MV_W'($urandom),
                              prechg_pkg::MV_W'($urandom));
                end else begin
                    // Ticks: most loads are at most half the pack, some sit right at the threshold.
                    roll = $urandom_range(0, 19);
                    pack_v = $urandom_range(0, 4000);
                    if (roll == 0) begin
                        pack_v = $urandom_range(0, 65535);
                        load_v = $urandom_range(0, 65535);
                    end else if (roll == 1) begin
                        load_v = 65535;
                    end else if (roll < 4) begin
                        tmp = pack_v * thr / 1000 + int'($urandom_range(0, 6)) - 3;
                        if (tmp < 0) tmp = 0;
                        if (tmp > 65535) tmp = 65535;
                        load_v = tmp;
                    end else begin
                        load_v = $urandom_range(0, pack_v / 2);
                    end
                    push_item(prechg_pkg::KIND_TICK, prechg_pkg::MV_W'(pack_v),
                              prechg_pkg::MV_W'(load_v));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Checked away from the rising edge so that freshly driven items are seen.
        while (feed_q.size() > 0 || in_valid || charge_results.size() > 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
